FILE: rtl/mjdcal_pkg.sv
package mjdcal_pkg;

  // pipeline depth, shared by control and both datapaths
  localparam int NumStages = 9;

  // input and fraction widths
  localparam int MjdW     = 23;
  localparam int FracBits = 32;

  // accepted day range and julian day offset (jdn + 32044)
  localparam logic signed [MjdW-1:0] MjdLow  = MjdW'(-678575);
  localparam logic signed [MjdW-1:0] MjdHigh = MjdW'(2973483);
  localparam int JdnOffset = 2400001 + 32044;

  // calendar divisors
  localparam int DivG = 146097;
  localparam int DivC = 36524;
  localparam int DivB = 1461;
  localparam int DivA = 365;
  localparam int DivM = 153;
  localparam int YearBase = 4800;

  // internal widths
  localparam int JW  = 23;   // j below 2^23
  localparam int GW  = 6;    // 400-year cycles
  localparam int DgW = 18;   // day in 400-year cycle
  localparam int DcW = 16;   // day in century
  localparam int BW  = 5;    // 4-year cycles in century
  localparam int DbW = 11;   // day in 4-year cycle
  localparam int DaW = 9;    // day in march-based year
  localparam int YW  = 15;   // march-based year

  // ceiling reciprocals, exact since x_max * divisor < 2^shift
  localparam int ShG  = 41;
  localparam int RgW  = 24;
  localparam logic [RgW-1:0] RecG = RgW'(((64'd1 << ShG) + 64'(DivG) - 64'd1) / 64'(DivG));
  localparam int ShB  = 27;
  localparam int RbW  = 17;
  localparam logic [RbW-1:0] RecB = RbW'(((64'd1 << ShB) + 64'(DivB) - 64'd1) / 64'(DivB));
  localparam int ShM  = 20;
  localparam int RmW  = 13;
  localparam logic [RmW-1:0] RecM = RmW'(((64'd1 << ShM) + 64'(DivM) - 64'd1) / 64'(DivM));

  // time of day carried down the pipeline
  typedef struct packed {
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    logic [FracBits-1:0] frac;
  } tod_t;

  // first day of march-based month m, minus one: (m + 4) * 153 / 5
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd122;
      4'd1:    r = 9'd153;
      4'd2:    r = 9'd183;
      4'd3:    r = 9'd214;
      4'd4:    r = 9'd244;
      4'd5:    r = 9'd275;
      4'd6:    r = 9'd306;
      4'd7:    r = 9'd336;
      4'd8:    r = 9'd367;
      4'd9:    r = 9'd397;
      4'd10:   r = 9'd428;
      4'd11:   r = 9'd459;
      default: r = 9'd122;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/mjdcal_ctrl.sv
module mjdcal_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             out_ready_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  output logic [mjdcal_pkg::NumStages-1:0] ld_o
);

  logic [mjdcal_pkg::NumStages-1:0] vld_q, vld_d;
  logic [mjdcal_pkg::NumStages:0]   rdy;

  // a stage loads when empty or when its contents move on
  always_comb begin
    rdy[mjdcal_pkg::NumStages] = out_ready_i;
    for (int k = mjdcal_pkg::NumStages - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    for (int k = 0; k < mjdcal_pkg::NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ld_o        = rdy[mjdcal_pkg::NumStages-1:0];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[mjdcal_pkg::NumStages-1];

`ifndef SYNTHESIS
  // back pressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // an accepted transaction occupies the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transaction not captured");

  // occupancy grows by one on accept without delivery
  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !(out_valid_o && out_ready_i)) |=>
      ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("transaction lost or duplicated on accept");

  // occupancy shrinks by one on delivery without accept
  a_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && in_ready_o) && out_valid_o && out_ready_i) |=>
      ($countones(vld_q) == $past($countones(vld_q)) - 1))
    else $error("transaction lost or duplicated on delivery");
`endif

endmodule

FILE: rtl/mjdcal_date.sv
module mjdcal_date (
  input  logic                                    clk_i,
  input  logic [mjdcal_pkg::NumStages-1:0]        ld_i,
  input  logic signed [mjdcal_pkg::MjdW-1:0]      mjd_day_i,
  output logic [13:0]                             year_o,
  output logic [3:0]                              month_o,
  output logic [4:0]                              day_of_month_o
);

  // stage registers
  logic [mjdcal_pkg::JW-1:0]  j0_q, j1_q;
  logic [mjdcal_pkg::GW-1:0]  g1_q, g2_q, g3_q, g4_q, g5_q;
  logic [mjdcal_pkg::DgW-1:0] dg2_q;
  logic [1:0]                 c3_q, c4_q, c5_q;
  logic [mjdcal_pkg::DcW-1:0] dc3_q, dc4_q;
  logic [mjdcal_pkg::BW-1:0]  b4_q, b5_q;
  logic [mjdcal_pkg::DbW-1:0] db5_q;
  logic [mjdcal_pkg::YW-1:0]  y6_q, y7_q;
  logic [mjdcal_pkg::DaW-1:0] da6_q, da7_q;
  logic [3:0]                 m7_q;
  logic [13:0]                year_q;
  logic [3:0]                 month_q;
  logic [4:0]                 dom_q;

  // next values
  logic signed [mjdcal_pkg::MjdW-1:0]       sat;
  logic [mjdcal_pkg::MjdW:0]                jsum;
  logic [mjdcal_pkg::JW+mjdcal_pkg::RgW-1:0] pg;
  logic [mjdcal_pkg::JW-1:0]                gprod;
  logic [1:0]                               c_d;
  logic [mjdcal_pkg::DgW-1:0]               csub;
  logic [mjdcal_pkg::DcW+mjdcal_pkg::RbW-1:0] pb;
  logic [mjdcal_pkg::DcW-1:0]               bprod;
  logic [1:0]                               a_d;
  logic [mjdcal_pkg::DbW-1:0]               asub;
  logic [mjdcal_pkg::YW-1:0]                y_d;
  logic [11:0]                              mnum;
  logic [11+mjdcal_pkg::RmW:0]              pm;
  logic [4:0]                               mq;
  logic [8:0]                               mstart;
  logic [9:0]                               dsum;
  logic                                     carry;
  logic [mjdcal_pkg::YW-1:0]                yr_full;
  logic [3:0]                               mo_d;

  // stage 0: clamp the day and form j
  always_comb begin
    if (mjd_day_i < mjdcal_pkg::MjdLow) begin
      sat = mjdcal_pkg::MjdLow;
    end else if (mjd_day_i > mjdcal_pkg::MjdHigh) begin
      sat = mjdcal_pkg::MjdHigh;
    end else begin
      sat = mjd_day_i;
    end
    jsum = {sat[mjdcal_pkg::MjdW-1], sat} + (mjdcal_pkg::MjdW+1)'(mjdcal_pkg::JdnOffset);
  end

  // stage 1: 400-year cycles by reciprocal
  assign pg = (mjdcal_pkg::JW+mjdcal_pkg::RgW)'(j0_q) *
              (mjdcal_pkg::JW+mjdcal_pkg::RgW)'(mjdcal_pkg::RecG);

  // stage 2: day within 400-year cycle
  assign gprod = mjdcal_pkg::JW'(g1_q) * mjdcal_pkg::JW'(mjdcal_pkg::DivG);

  // stage 3: centuries, capped at three
  always_comb begin
    if (dg2_q >= mjdcal_pkg::DgW'(3 * mjdcal_pkg::DivC)) begin
      c_d = 2'd3;
    end else if (dg2_q >= mjdcal_pkg::DgW'(2 * mjdcal_pkg::DivC)) begin
      c_d = 2'd2;
    end else if (dg2_q >= mjdcal_pkg::DgW'(mjdcal_pkg::DivC)) begin
      c_d = 2'd1;
    end else begin
      c_d = 2'd0;
    end
    csub = mjdcal_pkg::DgW'(c_d) * mjdcal_pkg::DgW'(mjdcal_pkg::DivC);
  end

  // stage 4: 4-year cycles by reciprocal
  assign pb = (mjdcal_pkg::DcW+mjdcal_pkg::RbW)'(dc3_q) *
              (mjdcal_pkg::DcW+mjdcal_pkg::RbW)'(mjdcal_pkg::RecB);

  // stage 5: day within 4-year cycle
  assign bprod = mjdcal_pkg::DcW'(b4_q) * mjdcal_pkg::DcW'(mjdcal_pkg::DivB);

  // stage 6: years, capped at three, and march-based year
  always_comb begin
    if (db5_q >= mjdcal_pkg::DbW'(3 * mjdcal_pkg::DivA)) begin
      a_d = 2'd3;
    end else if (db5_q >= mjdcal_pkg::DbW'(2 * mjdcal_pkg::DivA)) begin
      a_d = 2'd2;
    end else if (db5_q >= mjdcal_pkg::DbW'(mjdcal_pkg::DivA)) begin
      a_d = 2'd1;
    end else begin
      a_d = 2'd0;
    end
    asub = mjdcal_pkg::DbW'(a_d) * mjdcal_pkg::DbW'(mjdcal_pkg::DivA);
    y_d  = mjdcal_pkg::YW'(g5_q) * mjdcal_pkg::YW'(400) +
           mjdcal_pkg::YW'(c5_q) * mjdcal_pkg::YW'(100) +
           mjdcal_pkg::YW'(b5_q) * mjdcal_pkg::YW'(4) + mjdcal_pkg::YW'(a_d);
  end

  // stage 7: march-based month (da*5 + 308) / 153 - 2
  assign mnum = 12'({da6_q, 2'b00}) + 12'(da6_q) + 12'(308);
  assign pm   = (12+mjdcal_pkg::RmW)'(mnum) * (12+mjdcal_pkg::RmW)'(mjdcal_pkg::RecM);
  assign mq   = pm[mjdcal_pkg::ShM+4:mjdcal_pkg::ShM];

  // stage 8: civil year, month and day
  always_comb begin
    mstart  = mjdcal_pkg::month_start(m7_q);
    dsum    = 10'(da7_q) + 10'(123) - 10'(mstart);
    carry   = (m7_q >= 4'd10);
    yr_full = y7_q + mjdcal_pkg::YW'(carry) - mjdcal_pkg::YW'(mjdcal_pkg::YearBase);
    mo_d    = carry ? (m7_q - 4'd9) : (m7_q + 4'd3);
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      j0_q <= jsum[mjdcal_pkg::JW-1:0];
    end
    if (ld_i[1]) begin
      j1_q <= j0_q;
      g1_q <= pg[mjdcal_pkg::ShG+mjdcal_pkg::GW-1:mjdcal_pkg::ShG];
    end
    if (ld_i[2]) begin
      g2_q  <= g1_q;
      dg2_q <= mjdcal_pkg::DgW'(j1_q - gprod);
    end
    if (ld_i[3]) begin
      g3_q  <= g2_q;
      c3_q  <= c_d;
      dc3_q <= mjdcal_pkg::DcW'(dg2_q - csub);
    end
    if (ld_i[4]) begin
      g4_q  <= g3_q;
      c4_q  <= c3_q;
      dc4_q <= dc3_q;
      b4_q  <= pb[mjdcal_pkg::ShB+mjdcal_pkg::BW-1:mjdcal_pkg::ShB];
    end
    if (ld_i[5]) begin
      g5_q  <= g4_q;
      c5_q  <= c4_q;
      b5_q  <= b4_q;
      db5_q <= mjdcal_pkg::DbW'(dc4_q - bprod);
    end
    if (ld_i[6]) begin
      y6_q  <= y_d;
      da6_q <= mjdcal_pkg::DaW'(db5_q - asub);
    end
    if (ld_i[7]) begin
      y7_q  <= y6_q;
      da7_q <= da6_q;
      m7_q  <= 4'(mq - 5'd2);
    end
    if (ld_i[8]) begin
      year_q  <= yr_full[13:0];
      month_q <= mo_d;
      dom_q   <= dsum[4:0];
    end
  end

  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;

endmodule

FILE: rtl/mjdcal_tod.sv
module mjdcal_tod (
  input  logic                                  clk_i,
  input  logic [mjdcal_pkg::NumStages-1:0]      ld_i,
  input  logic [31:0]                           day_fraction_i,
  output mjdcal_pkg::tod_t                      tod_o
);

  localparam int FB = mjdcal_pkg::FracBits;

  logic [4:0]    h0_q;
  logic [FB-1:0] f0_q;
  logic [4:0]    h1_q;
  logic [5:0]    mi1_q;
  logic [FB-1:0] f1_q;
  mjdcal_pkg::tod_t tod_q [mjdcal_pkg::NumStages-1:2];

  logic [FB+4:0] p0;
  logic [FB+5:0] p1;
  logic [FB+5:0] p2;

  // hours, minutes, seconds: one scaling per stage
  assign p0 = (FB+5)'(day_fraction_i[FB-1:0]) * (FB+5)'(24);
  assign p1 = (FB+6)'(f0_q) * (FB+6)'(60);
  assign p2 = (FB+6)'(f1_q) * (FB+6)'(60);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      h0_q <= p0[FB+4:FB];
      f0_q <= p0[FB-1:0];
    end
    if (ld_i[1]) begin
      h1_q  <= h0_q;
      mi1_q <= p1[FB+5:FB];
      f1_q  <= p1[FB-1:0];
    end
    if (ld_i[2]) begin
      tod_q[2] <= '{hour: h1_q, minute: mi1_q, second: p2[FB+5:FB], frac: p2[FB-1:0]};
    end
    // align with the date path
    for (int k = 3; k < mjdcal_pkg::NumStages; k++) begin
      if (ld_i[k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign tod_o = tod_q[mjdcal_pkg::NumStages-1];

endmodule

FILE: rtl/mjd_to_calendar_datetime_top.sv
// channel  dir  tdata fields, lowest bit first
// s_axis   in   mjd_day[22:0] signed, day_fraction[54:23], zero pad [55]
// m_axis   out  year[13:0], month[17:14], day_of_month[22:18], hour[27:23],
//               minute[33:28], second[39:34], second_fraction[71:40]
//
// one transaction per cycle sustained while m_axis_tready_i is high
// the pipeline depth is set by the chain of reciprocal divisions in the date path
// reset clears only the stage valid bits; no data register is reset
// a stall holds each occupied stage with no empty stage after it, the rest keep filling
// s_axis_tready_o follows m_axis_tready_i through the stage valid bits
module mjd_to_calendar_datetime_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // mjd_day, day_fraction, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // year, month, day_of_month, hour, minute,
                                        // second, second_fraction
);

  logic [mjdcal_pkg::NumStages-1:0] ld;
  logic [13:0]                      year;
  logic [3:0]                       month;
  logic [4:0]                       dom;
  mjdcal_pkg::tod_t                 tod;

  // stage valid bits and load enables
  mjdcal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .ld_o        (ld)
  );

  // calendar date path
  mjdcal_date u_date (
    .clk_i          (clk_i),
    .ld_i           (ld),
    .mjd_day_i      (s_axis_tdata_i[22:0]),
    .year_o         (year),
    .month_o        (month),
    .day_of_month_o (dom)
  );

  // time of day path
  mjdcal_tod u_tod (
    .clk_i          (clk_i),
    .ld_i           (ld),
    .day_fraction_i (s_axis_tdata_i[54:23]),
    .tod_o          (tod)
  );

  // output packing
  assign m_axis_tdata_o = {tod.frac, tod.second, tod.minute, tod.hour, dom, month, year};

endmodule
